FILE: design/assert_macros.svh
// Assertion macros for the RTL of the geometry decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/wkb_pkg.sv
// Types and constants of the well-known-binary geometry stream decoder.
`timescale 1ns / 1ps

package wkb_pkg;

    localparam int WKB_COUNT_BITS = 32;

    // Geometry type codes as they appear in the encoding.
    localparam logic [2:0] GEOM_POINT         = 3'd1;
    localparam logic [2:0] GEOM_LINE          = 3'd2;
    localparam logic [2:0] GEOM_POLYGON       = 3'd3;
    localparam logic [2:0] GEOM_MULTI_POINT   = 3'd4;
    localparam logic [2:0] GEOM_MULTI_POLYGON = 3'd6;
    localparam logic [2:0] GEOM_MULTI_OFFSET  = 3'd3;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_ORDER     = 4'd1,
        PH_TYPE      = 4'd2,
        PH_PARTS_CNT = 4'd3,
        PH_IN_ORDER  = 4'd4,
        PH_IN_TYPE   = 4'd5,
        PH_RINGS_CNT = 4'd6,
        PH_PTS_CNT   = 4'd7,
        PH_COORD     = 4'd8
    } t_phase;

    typedef enum logic [1:0] {
        KIND_COORD = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_OUTER  = 2'd1,
        ERR_NESTED = 2'd2
    } t_err;

    typedef struct packed {
        t_kind       kind;
        logic [63:0] x_bits;
        logic [63:0] y_bits;
        logic [31:0] part_index;
        logic [31:0] ring_index;
        logic        geometry_done;
        logic [31:0] byte_total;
        t_err        error_code;
    } t_result;

    typedef struct packed {
        logic [31:0] word;
        logic [3:0]  fbi;
        logic        full;
    } t_word_step;

endpackage

FILE: design/wkb_geometry_stream_decoder.sv
// Well-known-binary geometry decoder: one encoded byte per word in, coordinates out.
//
// The decoder takes one byte of a well-known-binary geometry per input word and
// accepts a new byte in every cycle while s_axis_tready is high. Each byte is
// decoded in a single pass of logic from the parse state to a result register,
// so a result word is registered from the byte that causes it. The output side
// is a two-word buffer (output register plus skid register), so the input keeps
// taking bytes while one result waits; only when both are full does s_axis_tready
// drop. Set s_axis_tuser on the byte-order byte that opens a geometry; a start word
// drops any parse in progress. expected_type is read at every decision; writes on
// the configuration channel are taken at once.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wkb_geometry_stream_decoder
    import wkb_pkg::*;
#(
    parameter int COUNT_BITS = WKB_COUNT_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Configuration: expected_type.
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_data,
    // Input bytes.
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic         s_axis_tuser,   // [0] start_req
    // Results.
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [63:0] x_bits, [127:64] y_bits, [159:128] part_index, [191:160] ring_index,
    // [223:192] byte_total, [225:224] error_code, [231:226] zero
    output logic [231:0] m_axis_tdata,
    output logic [1:0]   m_axis_tuser,   // [1:0] kind
    output logic         m_axis_tlast    // [0] geometry_done
);

    localparam logic [32:0] CNT_CAP_W = 33'((64'd1 << COUNT_BITS) - 64'd1);
    localparam logic [COUNT_BITS-1:0] CNT_CAP = CNT_CAP_W[COUNT_BITS-1:0];
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

    // Parse state.
    t_phase                r_phase,        n_phase;
    logic [3:0]            r_fbi,          n_fbi;
    logic                  r_outer_le,     n_outer_le;
    logic                  r_inner_le,     n_inner_le;
    logic [31:0]           r_word,         n_word;
    logic [63:0]           r_x,            n_x;
    logic [63:0]           r_y,            n_y;
    logic [COUNT_BITS-1:0] r_parts_left,   n_parts_left;
    logic [COUNT_BITS-1:0] r_rings_left,   n_rings_left;
    logic [COUNT_BITS-1:0] r_points_left,  n_points_left;
    logic [31:0]           r_cur_part,     n_cur_part;
    logic [31:0]           r_cur_ring,     n_cur_ring;
    logic [31:0]           r_bytes_seen,   n_bytes_seen;
    logic [2:0]            r_exp_type;

    // Result path.
    t_result n_res;
    logic    n_res_valid;
    t_result r_out;
    t_result r_skid;
    logic    r_out_valid;
    logic    r_skid_valid;

    logic in_acc;
    logic out_take;
    logic multi_exp;
    logic [2:0] base_type;

    function automatic t_word_step word_step(input logic [31:0] word,
                                             input logic [3:0]  fbi,
                                             input logic [7:0]  b,
                                             input logic        little);
        t_word_step  ws;
        logic [31:0] base;
        base = (fbi[1:0] == 2'd0) ? 32'd0 : word;
        if (little) begin
            ws.word = base | ({24'd0, b} << {fbi[1:0], 3'b000});
        end else begin
            ws.word = {base[23:0], b};
        end
        ws.full = (fbi[1:0] == 2'd3);
        ws.fbi  = ws.full ? 4'd0 : {2'b00, fbi[1:0] + 2'd1};
        return ws;
    endfunction

    function automatic logic [COUNT_BITS-1:0] sat_count(input logic [31:0] v);
        return ({1'b0, v} > CNT_CAP_W) ? CNT_CAP : v[COUNT_BITS-1:0];
    endfunction

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_skid_valid;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_take      = r_out_valid && m_axis_tready;

    assign multi_exp = r_exp_type inside {[GEOM_MULTI_POINT:GEOM_MULTI_POLYGON]};
    assign base_type = multi_exp ? (r_exp_type - GEOM_MULTI_OFFSET) : r_exp_type;

    always_comb begin : p_next
        t_word_step ws;
        logic [3:0] k;
        logic       do_points;
        logic       do_part;
        logic       ended;
        logic       emit_done;
        logic       emit_coord;
        logic [31:0] snap_part;
        logic [31:0] snap_ring;

        n_phase       = r_phase;
        n_fbi         = r_fbi;
        n_outer_le    = r_outer_le;
        n_inner_le    = r_inner_le;
        n_word        = r_word;
        n_x           = r_x;
        n_y           = r_y;
        n_parts_left  = r_parts_left;
        n_rings_left  = r_rings_left;
        n_points_left = r_points_left;
        n_cur_part    = r_cur_part;
        n_cur_ring    = r_cur_ring;
        n_bytes_seen  = r_bytes_seen;
        n_res         = '0;
        n_res_valid   = 1'b0;
        ws            = '0;
        k             = r_fbi;
        do_points     = 1'b0;
        do_part       = 1'b0;
        ended         = 1'b0;
        emit_done     = 1'b0;
        emit_coord    = 1'b0;
        snap_part     = 32'd0;
        snap_ring     = 32'd0;

        if (s_axis_tuser) begin
            n_phase       = PH_ORDER;
            n_fbi         = 4'd0;
            n_bytes_seen  = 32'd0;
            n_parts_left  = '0;
            n_rings_left  = '0;
            n_points_left = '0;
            n_cur_part    = 32'd0;
            n_cur_ring    = 32'd0;
        end

        if (n_phase != PH_IDLE && !(&n_bytes_seen)) begin
            n_bytes_seen = n_bytes_seen + 32'd1;
        end

        case (n_phase)
            PH_IDLE: begin
            end
            PH_ORDER: begin
                n_outer_le = (s_axis_tdata != 8'd0);
                n_inner_le = n_outer_le;
                n_fbi      = 4'd0;
                n_phase    = PH_TYPE;
            end
            PH_TYPE: begin
                ws     = word_step(n_word, n_fbi, s_axis_tdata, n_outer_le);
                n_word = ws.word;
                n_fbi  = ws.fbi;
                if (ws.full) begin
                    if (r_exp_type < GEOM_POINT || r_exp_type > GEOM_MULTI_POLYGON ||
                        ws.word != {29'd0, r_exp_type}) begin
                        n_phase = PH_IDLE;
                        n_res_valid      = 1'b1;
                        n_res.kind       = KIND_ERROR;
                        n_res.byte_total = n_bytes_seen;
                        n_res.error_code = ERR_OUTER;
                    end else begin
                        n_cur_part = 32'd0;
                        if (multi_exp) begin
                            n_phase = PH_PARTS_CNT;
                        end else begin
                            n_cur_ring = 32'd0;
                            n_fbi      = 4'd0;
                            n_phase    = (base_type == GEOM_POINT) ? PH_COORD :
                                         (base_type == GEOM_LINE)  ? PH_PTS_CNT :
                                                                     PH_RINGS_CNT;
                        end
                    end
                end
            end
            PH_PARTS_CNT: begin
                ws     = word_step(n_word, n_fbi, s_axis_tdata, n_outer_le);
                n_word = ws.word;
                n_fbi  = ws.fbi;
                if (ws.full) begin
                    n_parts_left = sat_count(ws.word);
                    n_cur_part   = 32'd0;
                    if (n_parts_left == '0) begin
                        n_phase   = PH_IDLE;
                        emit_done = 1'b1;
                    end else begin
                        n_phase = PH_IN_ORDER;
                    end
                end
            end
            PH_IN_ORDER: begin
                n_inner_le = (s_axis_tdata != 8'd0);
                n_fbi      = 4'd0;
                n_phase    = PH_IN_TYPE;
            end
            PH_IN_TYPE: begin
                ws     = word_step(n_word, n_fbi, s_axis_tdata, n_inner_le);
                n_word = ws.word;
                n_fbi  = ws.fbi;
                if (ws.full) begin
                    if (ws.word != {29'd0, base_type}) begin
                        n_phase = PH_IDLE;
                        n_res_valid      = 1'b1;
                        n_res.kind       = KIND_ERROR;
                        n_res.byte_total = n_bytes_seen;
                        n_res.error_code = ERR_NESTED;
                    end else begin
                        n_cur_ring = 32'd0;
                        n_fbi      = 4'd0;
                        n_phase    = (base_type == GEOM_POINT) ? PH_COORD :
                                     (base_type == GEOM_LINE)  ? PH_PTS_CNT :
                                                                 PH_RINGS_CNT;
                    end
                end
            end
            PH_RINGS_CNT: begin
                ws     = word_step(n_word, n_fbi, s_axis_tdata, n_inner_le);
                n_word = ws.word;
                n_fbi  = ws.fbi;
                if (ws.full) begin
                    n_rings_left = sat_count(ws.word);
                    n_cur_ring   = 32'd0;
                    if (n_rings_left == '0) begin
                        do_part = 1'b1;
                    end else begin
                        n_phase = PH_PTS_CNT;
                    end
                end
            end
            PH_PTS_CNT: begin
                ws     = word_step(n_word, n_fbi, s_axis_tdata, n_inner_le);
                n_word = ws.word;
                n_fbi  = ws.fbi;
                if (ws.full) begin
                    n_points_left = sat_count(ws.word);
                    if (n_points_left == '0) begin
                        do_points = 1'b1;
                    end else begin
                        n_phase = PH_COORD;
                        n_fbi   = 4'd0;
                    end
                end
            end
            PH_COORD: begin
                k         = n_fbi;
                snap_part = n_cur_part;
                snap_ring = n_cur_ring;
                if (k == 4'd0) begin
                    n_x = 64'd0;
                    n_y = 64'd0;
                end
                // Bytes 0 to 7 build x, bytes 8 to 15 build y.
                if (!k[3]) begin
                    n_x = n_inner_le ? (n_x | ({56'd0, s_axis_tdata} << {k[2:0], 3'b000}))
                                     : {n_x[55:0], s_axis_tdata};
                end else begin
                    n_y = n_inner_le ? (n_y | ({56'd0, s_axis_tdata} << {k[2:0], 3'b000}))
                                     : {n_y[55:0], s_axis_tdata};
                end
                if (k != 4'd15) begin
                    n_fbi = k + 4'd1;
                end else begin
                    n_fbi      = 4'd0;
                    emit_coord = 1'b1;
                    if (base_type == GEOM_POINT) begin
                        do_part = 1'b1;
                    end else begin
                        if (n_points_left != '0) begin
                            n_points_left = n_points_left - CNT_ONE;
                        end
                        if (n_points_left == '0) begin
                            do_points = 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        // End of a ring or a line: step to the next ring or close the part.
        if (do_points) begin
            n_fbi = 4'd0;
            if (base_type == GEOM_POLYGON) begin
                if (n_rings_left != '0) begin
                    n_rings_left = n_rings_left - CNT_ONE;
                end
                n_cur_ring = n_cur_ring + 32'd1;
                if (n_rings_left != '0) begin
                    n_phase = PH_PTS_CNT;
                end else begin
                    do_part = 1'b1;
                end
            end else begin
                do_part = 1'b1;
            end
        end

        // End of a part: step to the next part or close the geometry.
        if (do_part) begin
            n_fbi = 4'd0;
            if (multi_exp) begin
                if (n_parts_left != '0) begin
                    n_parts_left = n_parts_left - CNT_ONE;
                end
                n_cur_part = n_cur_part + 32'd1;
                if (n_parts_left != '0) begin
                    n_phase = PH_IN_ORDER;
                end else begin
                    n_phase = PH_IDLE;
                    ended   = 1'b1;
                end
            end else begin
                n_phase = PH_IDLE;
                ended   = 1'b1;
            end
        end

        if (emit_coord) begin
            n_res_valid         = 1'b1;
            n_res.kind          = KIND_COORD;
            n_res.x_bits        = n_x;
            n_res.y_bits        = n_y;
            n_res.part_index    = snap_part;
            n_res.ring_index    = snap_ring;
            n_res.geometry_done = ended;
            n_res.byte_total    = ended ? n_bytes_seen : 32'd0;
        end else if (emit_done || ended) begin
            n_res_valid         = 1'b1;
            n_res.kind          = KIND_DONE;
            n_res.geometry_done = 1'b1;
            n_res.byte_total    = n_bytes_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_type <= GEOM_POLYGON;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_exp_type <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_fbi         <= 4'd0;
            r_outer_le    <= 1'b0;
            r_inner_le    <= 1'b0;
            r_parts_left  <= '0;
            r_rings_left  <= '0;
            r_points_left <= '0;
            r_cur_part    <= 32'd0;
            r_cur_ring    <= 32'd0;
            r_bytes_seen  <= 32'd0;
        end else if (in_acc) begin
            r_phase       <= n_phase;
            r_fbi         <= n_fbi;
            r_outer_le    <= n_outer_le;
            r_inner_le    <= n_inner_le;
            r_parts_left  <= n_parts_left;
            r_rings_left  <= n_rings_left;
            r_points_left <= n_points_left;
            r_cur_part    <= n_cur_part;
            r_cur_ring    <= n_cur_ring;
            r_bytes_seen  <= n_bytes_seen;
        end
    end

    // Assembly registers are cleared by the first byte of each field.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_word <= n_word;
            r_x    <= n_x;
            r_y    <= n_y;
        end
    end

    // Output register and skid register. The skid only fills when a new result
    // arrives while the output word is stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (in_acc && n_res_valid) begin
            if (!r_out_valid || out_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (in_acc && n_res_valid) begin
            if (!r_out_valid || out_take) begin
                r_out <= n_res;
            end else begin
                r_skid <= n_res;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out.geometry_done;
    assign m_axis_tdata  = {6'd0, r_out.error_code, r_out.byte_total, r_out.ring_index,
                            r_out.part_index, r_out.y_bits, r_out.x_bits};

    `ASSERT_IMPL(a_skid_implies_out, i_clk, i_rst_n, r_skid_valid, r_out_valid,
        "skid register holds a word while the output register is empty")

    `ASSERT_IMPL(a_error_shape, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tuser == KIND_ERROR,
        !m_axis_tlast && m_axis_tdata[225:224] != ERR_NONE,
        "error word carries a completion flag or no error code")

    `ASSERT_NEXT(a_idle_holds, i_clk, i_rst_n,
        in_acc && r_phase == PH_IDLE && !s_axis_tuser, r_phase == PH_IDLE,
        "decoder left idle without a start word")

    `ASSERT_IMPL(a_word_index_range, i_clk, i_rst_n,
        r_phase == PH_TYPE || r_phase == PH_PARTS_CNT || r_phase == PH_IN_TYPE ||
        r_phase == PH_RINGS_CNT || r_phase == PH_PTS_CNT,
        r_fbi[3:2] == 2'b00,
        "byte index of a 32-bit field out of range")

endmodule
